@@ design/rolling_hash_substring_match_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ROLLING_HASH_SUBSTRING_MATCH_MACROS_SVH
`define ROLLING_HASH_SUBSTRING_MATCH_MACROS_SVH

// property checked only while out of reset
`define RHSM_ASSERT_RUN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// property checked at every edge, reset included
`define RHSM_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rhsm_pkg.sv @@
// shared constants and types for the substring match block
package rhsm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        REQ_PATTERN = 1'b0,
        REQ_TEXT    = 1'b1
    } req_t;

    typedef struct packed {
        req_t              req_type;
        logic              first;
        logic [CHAR_W-1:0] char_byte;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

endpackage

@@ design/rhsm_front.sv @@
// front end: accepts input beats, classifies them and queues them for the back end
module rhsm_front
    import rhsm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,
    input  logic [1:0]        s_axis_tuser,
    output queue_out_t        head,
    input  logic              pop_ready
);

    item_t                q_item_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg, count_next;
    item_t                in_item;
    logic                 push, pop;

    always_comb begin
        in_item.req_type  = req_t'(s_axis_tuser[0]);
        in_item.first     = s_axis_tuser[1];
        in_item.char_byte = s_axis_tdata;
    end

    assign s_axis_tready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign head.valid    = (count_reg != '0);
    assign head.item     = q_item_reg[rd_ptr_reg];
    assign pop           = head.valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_item_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ design/rhsm_back.sv @@
// back end: pattern and text shift lines, exact window compare and result register
module rhsm_back
    import rhsm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  queue_out_t       head,
    output logic             pop_ready,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [POS_W-1:0] m_axis_tdata
);

    logic [CHAR_W-1:0] pat_tap_reg [PATTERN_MAX];
    logic [CHAR_W-1:0] win_tap_reg [PATTERN_MAX];
    logic [LEN_W-1:0]  pat_len_reg, pat_len_next;
    logic              pat_ovf_reg, pat_ovf_next;
    logic [POS_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_pos_reg;
    logic [PATTERN_MAX-1:0] tap_ok;
    logic [LEN_W-1:0]  len_base;
    logic [POS_W-1:0]  cnt_base;
    logic              pop, pat_shift, win_shift, hit, stall;

    // exact compare: pattern tap j lines up with window tap j
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            tap_ok[j] = (LEN_W'(j) >= pat_len_reg) || (pat_tap_reg[j] == win_tap_reg[j]);
        end
    end

    assign hit = pend_reg && (pat_len_reg != '0) && !pat_ovf_reg
                 && (cnt_reg >= POS_W'(pat_len_reg)) && (&tap_ok);
    assign stall     = hit && out_valid_reg && !m_axis_tready;
    assign pop_ready = !stall;
    assign pop       = head.valid && pop_ready;

    always_comb begin
        pat_len_next = pat_len_reg;
        pat_ovf_next = pat_ovf_reg;
        cnt_next     = cnt_reg;
        pat_shift    = 1'b0;
        win_shift    = 1'b0;
        len_base     = head.item.first ? '0 : pat_len_reg;
        cnt_base     = head.item.first ? '0 : cnt_reg;
        pend_next    = stall;
        if (pop) begin
            case (head.item.req_type)
                REQ_PATTERN: begin
                    cnt_next = '0;
                    if (head.item.first) begin
                        pat_ovf_next = 1'b0;
                    end
                    if (len_base >= LEN_W'(PATTERN_MAX)) begin
                        pat_len_next = len_base;
                        pat_ovf_next = 1'b1;
                    end else begin
                        pat_len_next = len_base + 1'b1;
                        pat_shift    = 1'b1;
                    end
                end
                REQ_TEXT: begin
                    win_shift = 1'b1;
                    pend_next = 1'b1;
                    cnt_next  = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + 1'b1;
                end
                default: begin
                    pend_next = stall;
                end
            endcase
        end
        out_valid_next = out_valid_reg;
        if (hit && !stall) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg   <= '0;
            pat_ovf_reg   <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            pat_len_reg   <= pat_len_next;
            pat_ovf_reg   <= pat_ovf_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // shift lines, newest byte at tap zero
    always_ff @(posedge aclk) begin
        if (pat_shift) begin
            pat_tap_reg[0] <= head.item.char_byte;
            for (int j = 1; j < PATTERN_MAX; j++) begin
                pat_tap_reg[j] <= pat_tap_reg[j-1];
            end
        end
        if (win_shift) begin
            win_tap_reg[0] <= head.item.char_byte;
            for (int j = 1; j < PATTERN_MAX; j++) begin
                win_tap_reg[j] <= win_tap_reg[j-1];
            end
        end
        if (hit && !stall) begin
            out_pos_reg <= cnt_reg - POS_W'(pat_len_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pos_reg;

endmodule

@@ design/rolling_hash_substring_match.sv @@
// top level of the exact substring match block
//
//  channel  dir  tdata                  tuser
//  s_axis   in   [7:0] char_byte        [0] req_type, [1] first
//  m_axis   out  [31:0] match_position  -
//
// one beat per cycle on both channels unless m_axis_tready stalls
// a match passes the queue, window line and result register to m_axis
// aresetn clears pattern length, text count, queue and result valid
// a two-entry queue parts the input from the compare stage; the compare
// stage holds a new match while a result waits on m_axis_tready
module rolling_hash_substring_match
    import rhsm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] char_byte
    input  logic [1:0]       s_axis_tuser,    // [0] req_type, [1] first
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [POS_W-1:0] m_axis_tdata     // [31:0] match_position
);

    queue_out_t head;
    logic       pop_ready;

    rhsm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head          (head),
        .pop_ready     (pop_ready)
    );

    rhsm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .pop_ready     (pop_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ design/rhsm_checker.sv @@
// port-level checks for the substring match block and their bind
`include "rolling_hash_substring_match_macros.svh"

module rhsm_checker
    import rhsm_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [POS_W-1:0] m_axis_tdata
);

    `RHSM_ASSERT_RUN(a_out_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result beat dropped or changed while stalled")
    `RHSM_ASSERT_RUN(a_pos_range, aclk, aresetn, m_axis_tvalid |-> (m_axis_tdata != COUNT_MAX), "match position beyond last possible start")
    `RHSM_ASSERT_ANY(a_rst_out, aclk, !aresetn |=> !m_axis_tvalid, "result valid right after reset")
    `RHSM_ASSERT_ANY(a_rst_ready, aclk, !aresetn |=> s_axis_tready, "input not ready right after reset")

endmodule

bind rolling_hash_substring_match rhsm_checker u_rhsm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/rhsm_match_monitor.sv @@
// checker for the substring match block: predicts match positions and compares the result channel
module rhsm_match_monitor
    import rhsm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,
    input  logic [1:0]        s_axis_tuser,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [POS_W-1:0]  m_axis_tdata,
    output int                fail_count,
    output int                pending_matches
);

    localparam logic [63:0] HASH_PRIME = 64'd1000000007;
    localparam logic [63:0] HASH_BASE  = 64'd263;

    logic [CHAR_W-1:0] pat_chars [PATTERN_MAX];
    logic [CHAR_W-1:0] recent    [PATTERN_MAX];
    int unsigned       pat_len;
    bit                pat_too_long;
    logic [POS_W-1:0]  chars_seen;
    logic [63:0]       pat_hash;
    logic [63:0]       recent_hash;
    logic [63:0]       lead_weight;
    logic [POS_W-1:0]  match_pos_q [$];

    task automatic forget_pattern();
        pat_len      = 0;
        pat_too_long = 1'b0;
        pat_hash     = '0;
        lead_weight  = 64'd1;
    endtask

    task automatic store_pattern_char(input logic [CHAR_W-1:0] ch, input logic restart);
        if (restart)
            forget_pattern();
        chars_seen  = '0;
        recent_hash = '0;
        if (pat_len >= PATTERN_MAX) begin
            pat_too_long = 1'b1;
        end else begin
            pat_chars[pat_len] = ch;
            pat_len++;
            pat_hash = (pat_hash * HASH_BASE + 64'(ch)) % HASH_PRIME;
            if (pat_len > 1)
                lead_weight = (lead_weight * HASH_BASE) % HASH_PRIME;
        end
    endtask

    task automatic roll_text_char(input logic [CHAR_W-1:0] ch, input logic restart);
        logic [63:0] dropped;
        bit          hit;
        if (restart) begin
            chars_seen  = '0;
            recent_hash = '0;
        end
        if (pat_len >= 1 && pat_len <= PATTERN_MAX) begin
            if (chars_seen >= pat_len) begin
                dropped     = (64'(recent[pat_len-1]) * lead_weight) % HASH_PRIME;
                recent_hash = (recent_hash + HASH_PRIME - dropped) % HASH_PRIME;
            end
            recent_hash = (recent_hash * HASH_BASE + 64'(ch)) % HASH_PRIME;
        end
        for (int k = PATTERN_MAX - 1; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = ch;
        if (chars_seen != COUNT_MAX)
            chars_seen++;
        // hash is only a prefilter, the byte compare decides
        if (pat_len != 0 && !pat_too_long && chars_seen >= pat_len
                && recent_hash == pat_hash) begin
            hit = 1'b1;
            for (int k = 0; k < pat_len; k++)
                if (pat_chars[k] != recent[pat_len-1-k])
                    hit = 1'b0;
            if (hit)
                match_pos_q = {match_pos_q, chars_seen - POS_W'(pat_len)};
        end
    endtask

    always @(posedge aclk) begin
        logic [POS_W-1:0] want;
        if (!aresetn) begin
            forget_pattern();
            chars_seen  = '0;
            recent_hash = '0;
            match_pos_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (match_pos_q.size() == 0) begin
                    $display("%0t: match_position expected none got %0d", $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = match_pos_q.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t: match_position expected %0d got %0d",
                                 $time, want, m_axis_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == REQ_TEXT)
                    roll_text_char(s_axis_tdata, s_axis_tuser[1]);
                else
                    store_pattern_char(s_axis_tdata, s_axis_tuser[1]);
            end
        end
        pending_matches = match_pos_q.size();
    end

endmodule

@@ test/tb_rolling_hash_substring_match.sv @@
// testbench top for the substring match block: stimulus, flow control and verdict
module tb_rolling_hash_substring_match;
    import rhsm_pkg::*;

    localparam int BEAT_TARGET   = 650;
    localparam int CALM_FROM     = 550;
    localparam int STALL_LIMIT   = 3000;
    localparam int SINK_HOLD     = 80;
    localparam int SETTLE_CYCLES = 16;

    logic              aclk;
    logic              aresetn;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [CHAR_W-1:0] s_axis_tdata;
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [POS_W-1:0]  m_axis_tdata;

    int                fail_count;
    int                pending_matches;
    int                beats_sent;
    bit                calm;
    bit                hold_req;
    logic [CHAR_W-1:0] sym [2];
    logic [CHAR_W-1:0] long_pat [PATTERN_MAX + 2];

    rolling_hash_substring_match dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rhsm_match_monitor monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .pending_matches (pending_matches)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 7) == 0)
            return CHAR_W'($urandom);
        return sym[$urandom_range(0, 1)];
    endfunction

    task automatic send_beat(input req_t kind, input logic first_flag,
                             input logic [CHAR_W-1:0] ch);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= {first_flag, kind};
        do @(posedge aclk); while (!s_axis_tready);
        beats_sent++;
    endtask

    task automatic drain(input int settle);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_matches != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        int sink_gap;
        bit hold_done;
        sink_gap      = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD) @(negedge aclk);
                m_axis_tready <= 1'b1;
                hold_done = 1'b1;
            end else if (sink_gap > 0) begin
                m_axis_tready <= 1'b0;
                sink_gap--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                sink_gap = $urandom_range(0, 9);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int plen;
        int tlen;
        int kind;
        int long_stage;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        beats_sent    = 0;
        long_stage    = 0;
        sym[0]        = '0;
        sym[1]        = '1;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // text with no pattern loaded
        send_beat(REQ_TEXT, 1'b1, 8'h78);
        send_beat(REQ_TEXT, 1'b0, 8'h79);
        // extreme bytes, repeated hits
        send_beat(REQ_PATTERN, 1'b1, 8'h00);
        send_beat(REQ_PATTERN, 1'b0, 8'hFF);
        send_beat(REQ_TEXT, 1'b1, 8'h00);
        send_beat(REQ_TEXT, 1'b0, 8'hFF);
        send_beat(REQ_TEXT, 1'b0, 8'h00);
        send_beat(REQ_TEXT, 1'b0, 8'hFF);
        // pattern built across beats, text restarted mid-stream
        send_beat(REQ_PATTERN, 1'b1, 8'hA5);
        send_beat(REQ_PATTERN, 1'b0, 8'h5A);
        send_beat(REQ_TEXT, 1'b1, 8'hA5);
        send_beat(REQ_TEXT, 1'b0, 8'h5A);
        send_beat(REQ_TEXT, 1'b0, 8'hA5);
        send_beat(REQ_TEXT, 1'b1, 8'h5A);
        send_beat(REQ_TEXT, 1'b0, 8'h5A);
        send_beat(REQ_TEXT, 1'b0, 8'hA5);
        send_beat(REQ_TEXT, 1'b0, 8'h5A);
        // pattern load clears text count even without a restart flag
        send_beat(REQ_PATTERN, 1'b1, 8'h81);
        send_beat(REQ_TEXT, 1'b0, 8'h81);

        // every text beat hits while the result side holds off
        hold_req = 1'b1;
        send_beat(REQ_PATTERN, 1'b1, 8'h3C);
        for (int i = 0; i < 24; i++)
            send_beat(REQ_TEXT, i == 0, 8'h3C);
        drain(0);

        while (beats_sent < BEAT_TARGET) begin
            if (beats_sent >= CALM_FROM)
                calm = 1'b1;
            sym[0] = CHAR_W'($urandom);
            sym[1] = sym[0] ^ (8'h01 << $urandom_range(0, 7));
            if (long_stage < 2 && beats_sent >= 150 + 150 * long_stage) begin
                // full-length pattern, then one that runs past the store
                plen = (long_stage == 0) ? PATTERN_MAX : PATTERN_MAX + 2;
                for (int i = 0; i < plen; i++) begin
                    long_pat[i] = pick_char();
                    send_beat(REQ_PATTERN, i == 0, long_pat[i]);
                end
                for (int i = 0; i < PATTERN_MAX + 2; i++)
                    send_beat(REQ_TEXT, i == 0,
                              (i < PATTERN_MAX) ? long_pat[i] : pick_char());
                long_stage++;
            end else begin
                kind = $urandom_range(0, 19);
                if (kind == 0) begin
                    tlen = $urandom_range(2, 6);
                    for (int i = 0; i < tlen; i++)
                        send_beat(req_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  CHAR_W'($urandom));
                end else begin
                    plen = $urandom_range(1, 5);
                    for (int i = 0; i < plen; i++)
                        send_beat(REQ_PATTERN, (i == 0) && (kind != 1), pick_char());
                    tlen = $urandom_range(8, 24);
                    for (int i = 0; i < tlen; i++)
                        send_beat(REQ_TEXT, (i == 0) || ($urandom_range(0, 19) == 0),
                                  pick_char());
                end
                if (kind == 2)
                    drain(0);
            end
        end

        drain(SETTLE_CYCLES);
        if (fail_count == 0 && pending_matches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/rhsm_pkg.sv
design/rhsm_front.sv
design/rhsm_back.sv
design/rolling_hash_substring_match.sv
design/rhsm_checker.sv
test/rhsm_match_monitor.sv
test/tb_rolling_hash_substring_match.sv
